@@ rtl/core/dvs_event_generator_with_overlay_macros.svh @@
`ifndef DVS_EVENT_GENERATOR_WITH_OVERLAY_MACROS_SVH
`define DVS_EVENT_GENERATOR_WITH_OVERLAY_MACROS_SVH

// checked only outside reset
`define DVSG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DVSG_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/dvsg_pkg.sv @@
`timescale 1ns / 1ps
package dvsg_pkg;

	localparam int DVSG_MAX_WIDTH  = 512;
	localparam int DVSG_MAX_HEIGHT = 512;

	localparam int LUMA_W     = 8;
	localparam int MODE_W     = 2;
	localparam int TIME_W     = 32;
	localparam int DIM_W      = 10;
	localparam int THR_W      = 8;
	localparam int COORD_W    = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	typedef logic [LUMA_W-1:0]     luma_t;
	typedef logic [MODE_W-1:0]     mode_t;
	typedef logic [TIME_W-1:0]     time_t;
	typedef logic [COORD_W-1:0]    coord_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t CFG_THRESHOLD = 2'd0;
	localparam cfg_idx_t CFG_WIDTH     = 2'd1;
	localparam cfg_idx_t CFG_HEIGHT    = 2'd2;

	localparam mode_t MODE_NONE   = 2'd0;
	localparam mode_t MODE_LOAD   = 2'd1;
	localparam mode_t MODE_ACTIVE = 2'd2;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd10;
	localparam logic [DIM_W-1:0] DIM_RESET       = 10'd512;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   polarity;
		time_t  t;
	} event_t;

endpackage

@@ rtl/core/dvsg_ifs.sv @@
`timescale 1ns / 1ps
interface dvsg_pixel_if;
	import dvsg_pkg::*;
	logic  valid;
	logic  ready;
	luma_t scene_luma;
	luma_t overlay_luma;
	luma_t overlay_alpha;
	mode_t overlay_mode;
	time_t frame_time_us;
	modport source (output valid, scene_luma, overlay_luma, overlay_alpha, overlay_mode,
		frame_time_us, input ready);
	modport sink (input valid, scene_luma, overlay_luma, overlay_alpha, overlay_mode,
		frame_time_us, output ready);
endinterface

interface dvsg_event_if;
	import dvsg_pkg::*;
	logic   valid;
	logic   ready;
	coord_t event_x;
	coord_t event_y;
	logic   polarity;
	time_t  event_time_us;
	modport source (output valid, event_x, event_y, polarity, event_time_us, input ready);
	modport sink (input valid, event_x, event_y, polarity, event_time_us, output ready);
endinterface

interface dvsg_cfg_if;
	import dvsg_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/dvs_event_generator_with_overlay.sv @@
`timescale 1ns / 1ps
// Event-camera emulator with overlay. Takes one grey pixel per clock in raster order and
// sustains one pixel per cycle while buffered events plus the pixel in stage 1 leave room
// in the four-entry output buffer: each pixel reads its scene and overlay reference bytes
// from two single-port-per-direction memories at its beat, then compares and writes back
// those its mode and threshold call for in the next cycle, with forwarding for a one-pixel
// frame that hits the same entry twice in a row. The first frame after reset only loads
// the scene reference. References start undefined, so overlay-active mode expects the
// overlay reference to have been loaded first.
`include "dvs_event_generator_with_overlay_macros.svh"
module dvs_event_generator_with_overlay #(
	parameter int MAX_WIDTH  = dvsg_pkg::DVSG_MAX_WIDTH,
	parameter int MAX_HEIGHT = dvsg_pkg::DVSG_MAX_HEIGHT
) (
	input logic          clk,
	input logic          arst_n,
	dvsg_pixel_if.sink   pixels,
	dvsg_event_if.source events,
	dvsg_cfg_if.sink     cfg
);
	import dvsg_pkg::*;

	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int RW         = $clog2(MAX_HEIGHT);
	localparam int AW         = CW + RW;
	localparam int DEPTH      = 1 << AW;
	localparam int MW         = (CW > RW) ? CW : RW;
	localparam int DW         = (MW + 1 > DIM_W) ? MW + 1 : DIM_W;
	localparam int XW         = (CW > COORD_W) ? CW : COORD_W;
	localparam int YW         = (RW > COORD_W) ? RW : COORD_W;
	localparam int FIFO_DEPTH = 4;
	localparam int FPW        = $clog2(FIFO_DEPTH);
	localparam int FCW        = FPW + 1;

	logic [THR_W-1:0] thr_q;
	logic [DIM_W-1:0] fw_q;
	logic [DIM_W-1:0] fh_q;
	logic [DW-1:0]    w_lim;
	logic [DW-1:0]    h_lim;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          primed_q;
	logic          accept;
	logic          last_col;
	logic          last_row;
	logic [AW-1:0] addr_s0;

	logic          s1_valid_q;
	logic [AW-1:0] addr_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	luma_t         scene_s1;
	luma_t         ovl_s1;
	luma_t         alpha_s1;
	mode_t         mode_s1;
	time_t         time_s1;
	logic          primed_s1;
	logic          sfwd_s1;
	luma_t         sfwd_data_s1;
	logic          ofwd_s1;
	luma_t         ofwd_data_s1;
	luma_t         scene_rd_s1;
	luma_t         ovl_rd_s1;

	luma_t scene_mem [DEPTH];
	luma_t ovl_mem [DEPTH];

	luma_t      scene_ref;
	luma_t      ovl_ref;
	luma_t      s_pos_d;
	luma_t      s_neg_d;
	luma_t      o_pos_d;
	luma_t      o_neg_d;
	logic       s_pos;
	logic       s_neg;
	logic       o_pos;
	logic       o_neg;
	logic       pos;
	logic       neg;
	logic       ovl_active;
	logic       scene_we;
	logic       ovl_we;
	logic       ev_fire;
	logic       ev_pol;
	logic [XW-1:0] col_pad;
	logic [YW-1:0] row_pad;
	event_t     ev_s1;

	event_t         fifo_q [FIFO_DEPTH];
	logic [FPW-1:0] wr_ptr_q;
	logic [FPW-1:0] rd_ptr_q;
	logic [FCW-1:0] count_q;
	logic [FCW-1:0] credit;
	logic           push;
	logic           pop;
	event_t         ev_head;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
			fw_q  <= DIM_RESET;
			fh_q  <= DIM_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_THRESHOLD: thr_q <= cfg.data[THR_W-1:0];
				CFG_WIDTH:     fw_q  <= cfg.data[DIM_W-1:0];
				CFG_HEIGHT:    fh_q  <= cfg.data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_lim = DW'(fw_q);
		if (fw_q == '0)
			w_lim = DW'(1);
		else if (w_lim > DW'(MAX_WIDTH))
			w_lim = DW'(MAX_WIDTH);
		h_lim = DW'(fh_q);
		if (fh_q == '0)
			h_lim = DW'(1);
		else if (h_lim > DW'(MAX_HEIGHT))
			h_lim = DW'(MAX_HEIGHT);
	end

	// raster position
	assign accept   = pixels.valid && pixels.ready;
	assign last_col = (DW'(col_q) + DW'(1)) >= w_lim;
	assign last_row = (DW'(row_q) + DW'(1)) >= h_lim;
	assign addr_s0  = {row_q, col_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			primed_q <= 1'b0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q    <= '0;
					primed_q <= 1'b1;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else
			s1_valid_q <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1      <= addr_s0;
			col_s1       <= col_q;
			row_s1       <= row_q;
			scene_s1     <= pixels.scene_luma;
			ovl_s1       <= pixels.overlay_luma;
			alpha_s1     <= pixels.overlay_alpha;
			mode_s1      <= pixels.overlay_mode;
			time_s1      <= pixels.frame_time_us;
			primed_s1    <= primed_q;
			sfwd_s1      <= s1_valid_q && scene_we && (addr_s1 == addr_s0);
			sfwd_data_s1 <= scene_s1;
			ofwd_s1      <= s1_valid_q && ovl_we && (addr_s1 == addr_s0);
			ofwd_data_s1 <= ovl_s1;
		end
	end

	// reference memories: read at the beat, write back in the next cycle
	always_ff @(posedge clk) begin
		if (accept)
			scene_rd_s1 <= scene_mem[addr_s0];
		if (s1_valid_q && scene_we)
			scene_mem[addr_s1] <= scene_s1;
	end

	always_ff @(posedge clk) begin
		if (accept)
			ovl_rd_s1 <= ovl_mem[addr_s0];
		if (s1_valid_q && ovl_we)
			ovl_mem[addr_s1] <= ovl_s1;
	end

	// compare and decide
	assign scene_ref  = sfwd_s1 ? sfwd_data_s1 : scene_rd_s1;
	assign ovl_ref    = ofwd_s1 ? ofwd_data_s1 : ovl_rd_s1;
	assign s_pos_d    = (scene_s1 > scene_ref) ? scene_s1 - scene_ref : '0;
	assign s_neg_d    = (scene_ref > scene_s1) ? scene_ref - scene_s1 : '0;
	assign o_pos_d    = (ovl_s1 > ovl_ref) ? ovl_s1 - ovl_ref : '0;
	assign o_neg_d    = (ovl_ref > ovl_s1) ? ovl_ref - ovl_s1 : '0;
	assign s_pos      = s_pos_d > thr_q;
	assign s_neg      = s_neg_d > thr_q;
	assign o_pos      = o_pos_d > thr_q;
	assign o_neg      = o_neg_d > thr_q;
	assign ovl_active = (mode_s1 != MODE_NONE) && (mode_s1 != MODE_LOAD);

	always_comb begin
		scene_we = 1'b0;
		ovl_we   = 1'b0;
		ev_fire  = 1'b0;
		pos      = s_pos;
		neg      = s_neg;
		priority if (!primed_s1) begin
			scene_we = 1'b1;
		end else if (mode_s1 == MODE_LOAD) begin
			ovl_we = 1'b1;
		end else begin
			scene_we = s_pos || s_neg;
			if (ovl_active) begin
				ovl_we = 1'b1;
				if (alpha_s1 != '0) begin
					pos = o_pos;
					neg = o_neg;
				end
			end
			ev_fire = pos || neg;
		end
		ev_pol = !pos;
	end

	assign col_pad     = XW'(col_s1);
	assign row_pad     = YW'(row_s1);
	assign ev_s1.x        = col_pad[COORD_W-1:0];
	assign ev_s1.y        = row_pad[COORD_W-1:0];
	assign ev_s1.polarity = ev_pol;
	assign ev_s1.t        = time_s1;

	// output buffer
	assign push          = s1_valid_q && ev_fire;
	assign pop           = events.valid && events.ready;
	assign credit        = count_q + FCW'(s1_valid_q);
	assign pixels.ready  = credit < FCW'(FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FPW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FPW'(1);
			count_q <= count_q + FCW'(push) - FCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= ev_s1;
	end

	assign ev_head              = fifo_q[rd_ptr_q];
	assign events.valid         = count_q != '0;
	assign events.event_x       = ev_head.x;
	assign events.event_y       = ev_head.y;
	assign events.polarity      = ev_head.polarity;
	assign events.event_time_us = ev_head.t;

	`DVSG_ASSERT(a_frame_end_primes, accept && last_col && last_row |=> primed_q, "last pixel of a frame did not set primed")
	`DVSG_ASSERT(a_no_push_when_full, push && !pop |-> count_q < FCW'(FIFO_DEPTH), "event pushed into a full output buffer")
	`DVSG_ASSERT(a_credit_bound, credit <= FCW'(FIFO_DEPTH), "more beats in flight than output buffer space")

endmodule
